// File: sv/bafc_pkg.sv
// bafc_pkg: shared types, constants and helpers for the barometric altitude filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package bafc_pkg;

  // temperature term: (T * coef + rnd) >> shift, per sensor generation
  localparam int unsigned TERM_COEF_OLD  = 50;
  localparam int unsigned TERM_RND_OLD   = 8;
  localparam int unsigned TERM_SHIFT_OLD = 4;
  localparam int unsigned TERM_COEF_NEW  = 62;
  localparam int unsigned TERM_RND_NEW   = 64;
  localparam int unsigned TERM_SHIFT_NEW = 7;

  // register reset values
  localparam logic        RST_SENSOR_TYPE   = 1'b1;
  localparam logic [18:0] RST_ORIGIN        = 19'd0;
  localparam logic [19:0] RST_GAIN          = 20'd2867;
  localparam logic [30:0] RST_JUMP_LIMIT    = 31'd655360;
  localparam logic [15:0] RST_TAU           = 16'd256;
  localparam logic [15:0] RST_PERIOD        = 16'd3277;

  localparam int unsigned REG_ADDR_W = 5;
  localparam int unsigned STEP_W     = 4;

  typedef enum logic [2:0] {
    REG_SENSOR_TYPE,
    REG_ORIGIN,
    REG_GAIN,
    REG_JUMP_LIMIT,
    REG_TAU,
    REG_PERIOD
  } reg_idx_t;

  typedef struct packed {
    logic        sensor_type;
    logic [18:0] origin_pressure;
    logic [19:0] count_gain;
    logic [30:0] jump_limit;
    logic [15:0] filter_tau;
    logic [15:0] update_period;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        raw_reading;
    logic               read_ok;
    logic               accel_valid;
    logic               near_level;
    logic               in_flight;
    logic signed [31:0] fallback_altitude;
  } sample_t;

  typedef struct packed {
    logic               next_is_pressure;
    logic               new_altitude;
    logic signed [31:0] altitude;
    logic signed [31:0] filtered_altitude;
    logic               jump_seen;
    logic [15:0]        failure_count;
    logic               sensor_failed;
  } result_t;

  // datapath operations, one per microcode step
  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_FRONT,   // decode reading, hold pressure or form compensated pressure
    ALU_ALT,     // raw altitude = sat(-p * gain)
    ALU_SLEW,    // jump check and slew limit
    ALU_ERR,     // e = sat(alt - est)
    ALU_TT,      // latch tau * tau
    ALU_ET,      // g = rnd(2 * e * tau, 8)
    ALU_HI,      // latch e * tt_hi
    ALU_F0,      // f0 from both partial products
    ALU_INT,     // integral update
    ALU_F1,      // f1 = sat(integral + g)
    ALU_EST,     // estimate update
    ALU_FB,      // estimate loaded from fallback
    ALU_DONE     // result register load
  } alu_op_t;

  typedef enum logic [1:0] {MA_P, MA_TAU, MA_ERR, MA_F} mul_a_t;
  typedef enum logic [2:0] {MB_GAIN, MB_TAU, MB_TT_HI, MB_TT_LO, MB_PERIOD} mul_b_t;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_NO_PAIR,
    JC_NO_FILTER,
    JC_ALWAYS,
    JC_END
  } jcond_t;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    alu_op_t alu;
    mul_a_t  ma;
    mul_b_t  mb;
    logic    mul_en;
    jcond_t  jc;
    step_t   target;
  } uword_t;

  typedef struct packed {
    logic no_pair;
    logic no_filter;
    logic out_free;
  } status_t;

  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] y;
    if (x > SAT_MAX) begin
      y = 32'sh7FFF_FFFF;
    end else if (x < SAT_MIN) begin
      y = 32'sh8000_0000;
    end else begin
      y = $signed(x[31:0]);
    end
    return y;
  endfunction

endpackage

`default_nettype wire

// File: sv/baro_altitude_filter_core.sv
// baro_altitude_filter_core: barometric altitude filter, top level.
// Path, accept to result_valid: the whole microprogram when a reading completes a pair and
// the filter runs, through the fallback load when the estimate loads the fallback altitude,
// and straight to the result load for a held pressure or failed read. One item at a time: the
// next beat is taken on the edge the result loads. The microprogram time-shares one 33x21 multiplier.
// Reset (rst, synchronous): registers to defaults, filter state cleared, output empty.
`default_nettype none

module baro_altitude_filter_core (
  input  logic                             clk,
  input  logic                             rst,
  // sample channel
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  bafc_pkg::sample_t                sample,
  // result channel
  output logic                             result_valid,
  input  logic                             result_stall,
  output bafc_pkg::result_t                result,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bafc_pkg::REG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import bafc_pkg::*;

  cfg_t    cfg;
  uword_t  uw;
  status_t status;
  logic    seq_free;
  logic    start;

  // A beat is taken whenever the sequencer is idle, or is on its final step and the
  // result register can take this item's result on the same edge.
  assign sample_stall = !seq_free;
  assign start        = sample_valid && seq_free;

  // Register file: sensor type, origin, gain, jump limit, filter tau, update period.
  bafc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Microprogram: front decode, then for a completed pair gain multiply, slew
  // limit and either the complementary filter (tau^2 split into halves over the
  // shared multiplier) or the fallback load; finally the result register load.
  bafc_ucode u_ucode (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .status   (status),
    .uw       (uw),
    .seq_free (seq_free)
  );

  // Datapath holds all filter state and the output register; results wait
  // there while the sequencer goes back to idle.
  bafc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample       (sample),
    .start        (start),
    .uw           (uw),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

// File: sv/bafc_regs.sv
// bafc_regs: APB-style configuration registers of the altitude filter.
// Depends on bafc_pkg (cfg_t, register indexes, reset values).
`default_nettype none

module bafc_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bafc_pkg::REG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output bafc_pkg::cfg_t                   cfg
);
  import bafc_pkg::*;

  logic [REG_ADDR_W-3:0] idx;
  logic                  wr;

  assign idx    = paddr[REG_ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensor_type     <= RST_SENSOR_TYPE;
      cfg.origin_pressure <= RST_ORIGIN;
      cfg.count_gain      <= RST_GAIN;
      cfg.jump_limit      <= RST_JUMP_LIMIT;
      cfg.filter_tau      <= RST_TAU;
      cfg.update_period   <= RST_PERIOD;
    end else if (wr) begin
      unique case (idx)
        REG_SENSOR_TYPE: cfg.sensor_type     <= pwdata[0];
        REG_ORIGIN:      cfg.origin_pressure <= pwdata[18:0];
        REG_GAIN:        cfg.count_gain      <= pwdata[19:0];
        REG_JUMP_LIMIT:  cfg.jump_limit      <= pwdata[30:0];
        REG_TAU:         cfg.filter_tau      <= pwdata[15:0];
        REG_PERIOD:      cfg.update_period   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SENSOR_TYPE: prdata = {31'd0, cfg.sensor_type};
      REG_ORIGIN:      prdata = {13'd0, cfg.origin_pressure};
      REG_GAIN:        prdata = {12'd0, cfg.count_gain};
      REG_JUMP_LIMIT:  prdata = {1'b0, cfg.jump_limit};
      REG_TAU:         prdata = {16'd0, cfg.filter_tau};
      REG_PERIOD:      prdata = {16'd0, cfg.update_period};
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/bafc_ucode.sv
// bafc_ucode: microcode ROM, step counter and jump logic of the altitude filter.
// Depends on bafc_pkg (uword_t, status_t, jump and operation codes).
`default_nettype none

module bafc_ucode (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  bafc_pkg::status_t  status,
  output bafc_pkg::uword_t   uw,
  output logic               seq_free
);
  import bafc_pkg::*;

  localparam step_t STEP_FRONT = step_t'(0);
  localparam step_t STEP_FB    = step_t'(14);
  localparam step_t STEP_FIN   = step_t'(15);

  typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_t;

  seq_state_t state;
  step_t      pc;
  uword_t     rom_word;

  function automatic uword_t mk(input alu_op_t alu, input mul_a_t ma, input mul_b_t mb,
                                input logic mul_en, input jcond_t jc, input step_t target);
    uword_t w;
    w.alu    = alu;
    w.ma     = ma;
    w.mb     = mb;
    w.mul_en = mul_en;
    w.jc     = jc;
    w.target = target;
    return w;
  endfunction

  // one control word per step; product of a mul step is ready on the next step
  function automatic uword_t rom(input step_t s);
    uword_t w;
    unique case (s)
      4'd0:  w = mk(ALU_FRONT, MA_P,   MB_GAIN,   1'b0, JC_NO_PAIR,   STEP_FIN);
      4'd1:  w = mk(ALU_NOP,   MA_P,   MB_GAIN,   1'b1, JC_NEXT,      STEP_FRONT);
      4'd2:  w = mk(ALU_ALT,   MA_P,   MB_GAIN,   1'b0, JC_NEXT,      STEP_FRONT);
      4'd3:  w = mk(ALU_SLEW,  MA_P,   MB_GAIN,   1'b0, JC_NO_FILTER, STEP_FB);
      4'd4:  w = mk(ALU_ERR,   MA_TAU, MB_TAU,    1'b1, JC_NEXT,      STEP_FRONT);
      4'd5:  w = mk(ALU_TT,    MA_ERR, MB_TAU,    1'b1, JC_NEXT,      STEP_FRONT);
      4'd6:  w = mk(ALU_ET,    MA_ERR, MB_TT_HI,  1'b1, JC_NEXT,      STEP_FRONT);
      4'd7:  w = mk(ALU_HI,    MA_ERR, MB_TT_LO,  1'b1, JC_NEXT,      STEP_FRONT);
      4'd8:  w = mk(ALU_F0,    MA_P,   MB_GAIN,   1'b0, JC_NEXT,      STEP_FRONT);
      4'd9:  w = mk(ALU_NOP,   MA_F,   MB_PERIOD, 1'b1, JC_NEXT,      STEP_FRONT);
      4'd10: w = mk(ALU_INT,   MA_P,   MB_GAIN,   1'b0, JC_NEXT,      STEP_FRONT);
      4'd11: w = mk(ALU_F1,    MA_P,   MB_GAIN,   1'b0, JC_NEXT,      STEP_FRONT);
      4'd12: w = mk(ALU_NOP,   MA_F,   MB_PERIOD, 1'b1, JC_NEXT,      STEP_FRONT);
      4'd13: w = mk(ALU_EST,   MA_P,   MB_GAIN,   1'b0, JC_ALWAYS,    STEP_FIN);
      4'd14: w = mk(ALU_FB,    MA_P,   MB_GAIN,   1'b0, JC_NEXT,      STEP_FRONT);
      4'd15: w = mk(ALU_DONE,  MA_P,   MB_GAIN,   1'b0, JC_END,       STEP_FRONT);
    endcase
    return w;
  endfunction

  assign rom_word = rom(pc);
  assign uw       = (state == SEQ_RUN) ? rom_word
                                       : mk(ALU_NOP, MA_P, MB_GAIN, 1'b0, JC_NEXT, STEP_FRONT);
  assign seq_free = (state == SEQ_IDLE) || (rom_word.jc == JC_END && status.out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      pc    <= STEP_FRONT;
    end else if (start) begin
      state <= SEQ_RUN;
      pc    <= STEP_FRONT;
    end else if (state == SEQ_RUN) begin
      unique case (rom_word.jc)
        JC_NEXT:      pc <= pc + step_t'(1);
        JC_NO_PAIR:   pc <= status.no_pair ? rom_word.target : pc + step_t'(1);
        JC_NO_FILTER: pc <= status.no_filter ? rom_word.target : pc + step_t'(1);
        JC_ALWAYS:    pc <= rom_word.target;
        JC_END: begin
          if (status.out_free) begin
            state <= SEQ_IDLE;
          end
        end
        default:      pc <= pc;
      endcase
    end
  end

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == SEQ_RUN) && (pc == STEP_FRONT))
    else $error("sequencer did not start at the first step");

endmodule

`default_nettype wire

// File: sv/bafc_datapath.sv
// bafc_datapath: state registers, shared 33x21 multiplier and step operations.
// Depends on bafc_pkg (cfg/sample/result types, control word, sat32).
`default_nettype none

module bafc_datapath (
  input  logic               clk,
  input  logic               rst,
  input  bafc_pkg::cfg_t     cfg,
  input  bafc_pkg::sample_t  sample,
  input  logic               start,
  input  bafc_pkg::uword_t   uw,
  output bafc_pkg::status_t  status,
  output logic               result_valid,
  input  logic               result_stall,
  output bafc_pkg::result_t  result
);
  import bafc_pkg::*;

  // model state
  logic               expect_pressure;
  logic [15:0]        held_pressure;
  logic signed [31:0] last_altitude;
  logic signed [31:0] filter_estimate;
  logic signed [31:0] filter_integral;
  logic [15:0]        fail_tally;
  logic               fail_latch;
  logic               made;
  logic               jump;

  // working registers
  sample_t            smp;
  logic signed [20:0] p_reg;
  logic signed [31:0] alt_reg;
  logic signed [31:0] err;
  logic [31:0]        tt;
  logic signed [41:0] g;
  logic signed [47:0] h;
  logic signed [31:0] f;
  logic signed [53:0] prod;

  logic signed [32:0] mul_a;
  logic signed [20:0] mul_b;
  logic [21:0]        term_scaled;
  logic [21:0]        p_wide;
  logic [15:0]        tally_inc;
  logic signed [33:0] hi;
  logic signed [33:0] lo;
  logic signed [33:0] alt34;
  logic               jump_now;
  logic signed [31:0] slew_alt;
  logic signed [63:0] prod_r16;

  function automatic logic signed [63:0] rnd16(input logic signed [53:0] x);
    return (64'(x) + 64'sd32768) >>> 16;
  endfunction

  // temperature term and compensated pressure
  always_comb begin
    if (cfg.sensor_type) begin
      term_scaled = (22'(smp.raw_reading) * 22'(TERM_COEF_NEW) + 22'(TERM_RND_NEW))
                    >> TERM_SHIFT_NEW;
    end else begin
      term_scaled = (22'(smp.raw_reading) * 22'(TERM_COEF_OLD) + 22'(TERM_RND_OLD))
                    >> TERM_SHIFT_OLD;
    end
    p_wide = 22'(held_pressure) + term_scaled - 22'(cfg.origin_pressure);
  end

  always_comb begin
    unique case (uw.ma)
      MA_P:    mul_a = 33'(p_reg);
      MA_TAU:  mul_a = $signed({17'd0, cfg.filter_tau});
      MA_ERR:  mul_a = 33'(err);
      MA_F:    mul_a = 33'(f);
      default: mul_a = '0;
    endcase
    unique case (uw.mb)
      MB_GAIN:   mul_b = $signed({1'b0, cfg.count_gain});
      MB_TAU:    mul_b = $signed({5'd0, cfg.filter_tau});
      MB_TT_HI:  mul_b = $signed({5'd0, tt[31:16]});
      MB_TT_LO:  mul_b = $signed({5'd0, tt[15:0]});
      MB_PERIOD: mul_b = $signed({5'd0, cfg.update_period});
      default:   mul_b = '0;
    endcase
  end

  // slew limit against the previous altitude
  always_comb begin
    hi       = 34'(last_altitude) + $signed({3'd0, cfg.jump_limit});
    lo       = 34'(last_altitude) - $signed({3'd0, cfg.jump_limit});
    alt34    = 34'(alt_reg);
    jump_now = (alt34 > hi) || (alt34 < lo);
    if (alt34 > hi) begin
      slew_alt = $signed(hi[31:0]);
    end else if (alt34 < lo) begin
      slew_alt = $signed(lo[31:0]);
    end else begin
      slew_alt = alt_reg;
    end
  end

  assign tally_inc = (fail_tally == 16'hFFFF) ? fail_tally : fail_tally + 16'd1;
  assign prod_r16  = rnd16(prod);

  assign status.no_pair   = !smp.read_ok || expect_pressure;
  assign status.no_filter = !(smp.accel_valid && smp.near_level);
  assign status.out_free  = !result_valid || !result_stall;

  // state with reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_pressure <= 1'b1;
      held_pressure   <= '0;
      last_altitude   <= '0;
      filter_estimate <= '0;
      filter_integral <= '0;
      fail_tally      <= '0;
      fail_latch      <= 1'b0;
      made            <= 1'b0;
      jump            <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      // a new load wins over the drain of the previous beat
      if (uw.alu == ALU_DONE && status.out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (uw.alu)
        ALU_FRONT: begin
          made <= 1'b0;
          jump <= 1'b0;
          if (!smp.read_ok) begin
            expect_pressure <= 1'b1;
            if (smp.in_flight) begin
              fail_tally <= tally_inc;
              fail_latch <= 1'b1;
            end
          end else if (expect_pressure) begin
            held_pressure   <= smp.raw_reading;
            expect_pressure <= 1'b0;
          end else begin
            expect_pressure <= 1'b1;
            made            <= 1'b1;
          end
        end
        ALU_SLEW: begin
          jump          <= jump_now;
          last_altitude <= slew_alt;
          if (jump_now) begin
            fail_tally <= tally_inc;
          end
        end
        ALU_INT:  filter_integral <= sat32(64'(filter_integral) + prod_r16);
        ALU_EST:  filter_estimate <= sat32(64'(filter_estimate) + prod_r16);
        ALU_FB:   filter_estimate <= smp.fallback_altitude;
        default: ;
      endcase
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    if (start) begin
      smp <= sample;
    end
    if (uw.mul_en) begin
      prod <= mul_a * mul_b;
    end
    unique case (uw.alu)
      ALU_FRONT: p_reg   <= $signed(p_wide[20:0]);
      ALU_ALT:   alt_reg <= sat32(-(64'(prod)));
      ALU_ERR:   err     <= sat32(64'(last_altitude) - 64'(filter_estimate));
      ALU_TT:    tt      <= prod[31:0];
      ALU_ET:    g       <= 42'(((64'(prod) <<< 1) + 64'sd128) >>> 8);
      ALU_HI:    h       <= $signed(prod[47:0]);
      ALU_F0:    f       <= sat32(64'(h) + prod_r16);
      ALU_F1:    f       <= sat32(64'(filter_integral) + 64'(g));
      ALU_DONE: begin
        if (status.out_free) begin
          result.next_is_pressure  <= expect_pressure;
          result.new_altitude      <= made;
          result.altitude          <= last_altitude;
          result.filtered_altitude <= filter_estimate;
          result.jump_seen         <= jump;
          result.failure_count     <= fail_tally;
          result.sensor_failed     <= fail_latch;
        end
      end
      default: ;
    endcase
  end

  a_latch_sticky: assert property (@(posedge clk) disable iff (rst)
    fail_latch |=> fail_latch)
    else $error("sensor failure flag dropped");

  a_tally_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(fail_tally) |=> fail_tally >= $past(fail_tally))
    else $error("failure tally decreased");

  a_pair_then_pressure: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.new_altitude |-> result.next_is_pressure)
    else $error("completed pair must request a pressure conversion");

endmodule

`default_nettype wire

// File: tb/baro_altitude_filter_core_tb.sv
// Testbench for baro_altitude_filter_core: sequencing, read failures, jump counting,
// the filter stage and register extremes. Beats are checked against an in-bench predictor.
// Depends on bafc_pkg and the core RTL only.
`timescale 1ns / 100ps

module baro_altitude_filter_core_tb;
  import bafc_pkg::*;

  localparam int     CLK_PERIOD     = 20;
  localparam int     RESET_CYCLES   = 8;
  localparam int     SETTLE_CYCLES  = 24;
  localparam longint TIMEOUT_CYCLES = 3_000_000;
  localparam int     IDLE_PCT       = 17;
  localparam int     MAX_GAP        = 18;
  localparam int     MAX_PRINTED    = 50;
  localparam int     RANDOM_PHASES  = 6;
  localparam int     PHASE_ITEMS    = 150;

  localparam logic [15:0]           TALLY_FULL    = 16'hFFFF;
  localparam logic [18:0]           ORIGIN_MAX    = 19'd270332;
  localparam logic [REG_ADDR_W-1:0] ADDR_UNMAPPED = REG_ADDR_W'(24);

  logic clk;
  logic rst;
  logic sample_valid;
  logic sample_stall;
  sample_t sample_beat;
  logic result_valid;
  logic result_stall;
  result_t result_beat;
  logic psel;
  logic penable;
  logic pwrite;
  logic [REG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // predictor state: registers plus the filter's own state
  cfg_t               cfg_mirror;
  logic               want_pressure;
  logic [15:0]        held_press;
  logic signed [31:0] last_alt;
  logic signed [31:0] est_model;
  logic signed [31:0] integ_model;
  logic [15:0]        tally_model;
  logic               fail_latched;

  result_t altitude_reports_due[$];

  bit sender_idle_en;
  bit stall_en;

  int n_errors;
  int n_samples;
  int n_updates;
  int n_failed_reads;
  int n_jumps;
  int n_fallback_loads;

  baro_altitude_filter_core dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_beat),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // hard stop in case a handshake hangs
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timeout at %0t: %0d beats still outstanding", $time, altitude_reports_due.size());
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // reporting
  // ---------------------------------------------------------------------------------------

  // every mismatch is counted; printing stops after a while to keep the log short
  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= MAX_PRINTED) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------------------

  function automatic logic signed [31:0] clamp32(input longint x);
    if (x > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (x < -longint'(64'sh8000_0000)) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  // floor((x + 2^(sh-1)) / 2^sh), i.e. round half up
  function automatic longint round_shift(input longint x, input int sh);
    return (x + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint temp_term(input logic newer, input logic [15:0] raw);
    if (newer) begin
      return (longint'(raw) * longint'(TERM_COEF_NEW) + longint'(TERM_RND_NEW))
             >>> TERM_SHIFT_NEW;
    end
    return (longint'(raw) * longint'(TERM_COEF_OLD) + longint'(TERM_RND_OLD))
           >>> TERM_SHIFT_OLD;
  endfunction

  function automatic void reset_model();
    cfg_mirror.sensor_type     = RST_SENSOR_TYPE;
    cfg_mirror.origin_pressure = RST_ORIGIN;
    cfg_mirror.count_gain      = RST_GAIN;
    cfg_mirror.jump_limit      = RST_JUMP_LIMIT;
    cfg_mirror.filter_tau      = RST_TAU;
    cfg_mirror.update_period   = RST_PERIOD;
    want_pressure = 1'b1;
    held_press    = '0;
    last_alt      = '0;
    est_model     = '0;
    integ_model   = '0;
    tally_model   = '0;
    fail_latched  = 1'b0;
  endfunction

  // one accepted reading -> the beat the core must return for it
  function automatic result_t predict_filter_step(input sample_t s);
    result_t r;
    longint  p, alt, diff, lim, e, tau, per, f0, f1;
    logic    made;
    logic    jump;
    made = 1'b0;
    jump = 1'b0;
    if (!s.read_ok) begin
      n_failed_reads++;
      want_pressure = 1'b1;
      if (s.in_flight) begin
        if (tally_model != TALLY_FULL) tally_model += 16'd1;
        fail_latched = 1'b1;
      end
    end else if (want_pressure) begin
      held_press    = s.raw_reading;
      want_pressure = 1'b0;
    end else begin
      want_pressure = 1'b1;
      made = 1'b1;
      p = longint'(held_press) + temp_term(cfg_mirror.sensor_type, s.raw_reading)
          - longint'(cfg_mirror.origin_pressure);
      alt = longint'(clamp32(-(p * longint'(cfg_mirror.count_gain))));

      // jump count, then slew limit against the previous altitude
      lim  = longint'(cfg_mirror.jump_limit);
      diff = alt - longint'(last_alt);
      if (diff > lim || -diff > lim) begin
        jump = 1'b1;
        n_jumps++;
        if (tally_model != TALLY_FULL) tally_model += 16'd1;
      end
      if (alt > longint'(last_alt) + lim) alt = longint'(last_alt) + lim;
      if (alt < longint'(last_alt) - lim) alt = longint'(last_alt) - lim;
      last_alt = alt[31:0];

      if (s.accel_valid && s.near_level) begin
        tau = longint'(cfg_mirror.filter_tau);
        per = longint'(cfg_mirror.update_period);
        e   = longint'(clamp32(alt - longint'(est_model)));
        f0  = longint'(clamp32(round_shift(e * (tau * tau), 16)));
        integ_model = clamp32(longint'(integ_model) + round_shift(f0 * per, 16));
        f1  = longint'(clamp32(longint'(integ_model) + round_shift(2 * e * tau, 8)));
        est_model = clamp32(longint'(est_model) + round_shift(f1 * per, 16));
      end else begin
        n_fallback_loads++;
        est_model = s.fallback_altitude;
      end
      n_updates++;
    end
    r.next_is_pressure  = want_pressure;
    r.new_altitude      = made;
    r.altitude          = last_alt;
    r.filtered_altitude = est_model;
    r.jump_seen         = jump;
    r.failure_count     = tally_model;
    r.sensor_failed     = fail_latched;
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // result side: random stall and the checker
  // ---------------------------------------------------------------------------------------

  always @(posedge clk) begin
    result_stall <= stall_en && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // values read here are the ones that stood before this edge
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (altitude_reports_due.size() == 0) begin
        report_mismatch("result beat with no expectation pending");
      end else begin
        want = altitude_reports_due.pop_front();
        check_field("next_is_pressure", longint'(result_beat.next_is_pressure),
                    longint'(want.next_is_pressure));
        check_field("new_altitude", longint'(result_beat.new_altitude),
                    longint'(want.new_altitude));
        check_field("altitude", longint'(result_beat.altitude), longint'(want.altitude));
        check_field("filtered_altitude", longint'(result_beat.filtered_altitude),
                    longint'(want.filtered_altitude));
        check_field("jump_seen", longint'(result_beat.jump_seen), longint'(want.jump_seen));
        check_field("failure_count", longint'(result_beat.failure_count),
                    longint'(want.failure_count));
        check_field("sensor_failed", longint'(result_beat.sensor_failed),
                    longint'(want.sensor_failed));
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // sample side
  // ---------------------------------------------------------------------------------------

  // Called on a clock edge. Returns on the edge the beat is taken, with valid still high,
  // so a following call can put the next payload out in the same step.
  task automatic send_sample(input sample_t s);
    if (sender_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_beat  <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    n_samples++;
    altitude_reports_due.push_back(predict_filter_step(s));
  endtask

  function automatic sample_t make_sample(input logic [15:0] raw, input logic ok,
                                          input logic acc, input logic lvl,
                                          input logic fly, input logic [31:0] fb);
    sample_t s;
    s.raw_reading       = raw;
    s.read_ok           = ok;
    s.accel_valid       = acc;
    s.near_level        = lvl;
    s.in_flight         = fly;
    s.fallback_altitude = fb;
    return s;
  endfunction

  task automatic send_pair(input logic [15:0] press, input logic [15:0] temp,
                           input logic acc, input logic lvl, input logic [31:0] fb);
    send_sample(make_sample(press, 1'b1, acc, lvl, 1'b0, fb));
    send_sample(make_sample(temp, 1'b1, acc, lvl, 1'b0, fb));
  endtask

  // block idle: nothing outstanding and the microprogram has run out
  task automatic drain();
    sample_valid <= 1'b0;
    while (altitude_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------------------------

  function automatic logic [REG_ADDR_W-1:0] reg_addr(input reg_idx_t idx);
    return REG_ADDR_W'({idx, 2'b00});
  endfunction

  function automatic logic [31:0] reg_value(input reg_idx_t idx);
    case (idx)
      REG_SENSOR_TYPE: return 32'(cfg_mirror.sensor_type);
      REG_ORIGIN:      return 32'(cfg_mirror.origin_pressure);
      REG_GAIN:        return 32'(cfg_mirror.count_gain);
      REG_JUMP_LIMIT:  return 32'(cfg_mirror.jump_limit);
      REG_TAU:         return 32'(cfg_mirror.filter_tau);
      REG_PERIOD:      return 32'(cfg_mirror.update_period);
      default:         return '0;
    endcase
  endfunction

  // setup then access, then idle with psel low so back-to-back calls never share a step
  task automatic apb_transfer(input logic wr, input logic [REG_ADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_ADDR_W-1:0] addr, input logic [31:0] value);
    logic [31:0] unused;
    apb_transfer(1'b1, addr, value, unused);
    case (reg_idx_t'(addr[REG_ADDR_W-1:2]))
      REG_SENSOR_TYPE: cfg_mirror.sensor_type     = value[0];
      REG_ORIGIN:      cfg_mirror.origin_pressure = value[18:0];
      REG_GAIN:        cfg_mirror.count_gain      = value[19:0];
      REG_JUMP_LIMIT:  cfg_mirror.jump_limit      = value[30:0];
      REG_TAU:         cfg_mirror.filter_tau      = value[15:0];
      REG_PERIOD:      cfg_mirror.update_period   = value[15:0];
      default:         ;  // unmapped: dropped by the core
    endcase
  endtask

  task automatic check_registers();
    logic [31:0] got;
    reg_idx_t    r;
    for (int i = REG_SENSOR_TYPE; i <= REG_PERIOD; i++) begin
      r = reg_idx_t'(i);
      apb_transfer(1'b0, reg_addr(r), '0, got);
      check_field($sformatf("register %s readback", r.name()), longint'(got),
                  longint'(reg_value(r)));
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------------------

  task automatic test_register_reset();
    check_registers();
  endtask

  // pairing, slew limit, both fallback triggers, filter from a saturated estimate
  task automatic test_pair_sequencing();
    send_pair(16'h0000, 16'h0000, 1'b1, 1'b1, 32'h0000_0000);
    send_pair(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 32'h0000_0000);
    send_pair(16'd30000, 16'd20000, 1'b0, 1'b1, 32'h8000_0000);
    send_pair(16'd30000, 16'd20000, 1'b1, 1'b0, 32'h7FFF_FFFF);
    send_pair(16'd30000, 16'd20000, 1'b1, 1'b1, 32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_read_failures();
    // failed read on the ground while a temperature is due: back to pressure, no count
    send_sample(make_sample(16'd1234, 1'b1, 1'b1, 1'b1, 1'b0, '0));
    send_sample(make_sample(16'd5678, 1'b0, 1'b1, 1'b1, 1'b0, '0));
    // failed read in flight while a temperature is due: counted and latched
    send_sample(make_sample(16'd1234, 1'b1, 1'b1, 1'b1, 1'b1, '0));
    send_sample(make_sample(16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b1, '0));
    // failed read in flight while a pressure is due
    send_sample(make_sample(16'h0000, 1'b0, 1'b0, 1'b0, 1'b1, '0));
    send_pair(16'd1234, 16'd4321, 1'b1, 1'b1, 32'h0001_0000);
    drain();
  endtask

  task automatic test_config_extremes();
    // older sensor, origin at ORIGIN_MAX and every other register at its top value: altitude and filter saturate
    write_reg(reg_addr(REG_SENSOR_TYPE), 32'd0);
    write_reg(reg_addr(REG_ORIGIN), 32'(ORIGIN_MAX));
    write_reg(reg_addr(REG_GAIN), 32'h000F_FFFF);
    write_reg(reg_addr(REG_JUMP_LIMIT), 32'h7FFF_FFFF);
    write_reg(reg_addr(REG_TAU), 32'h0000_FFFF);
    write_reg(reg_addr(REG_PERIOD), 32'h0000_FFFF);
    check_registers();
    send_pair(16'h0000, 16'h0000, 1'b1, 1'b1, '0);
    send_pair(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, '0);
    drain();

    // zero jump limit freezes the altitude; zero tau and period freeze the filter
    write_reg(reg_addr(REG_SENSOR_TYPE), 32'd1);
    write_reg(reg_addr(REG_ORIGIN), 32'd0);
    write_reg(reg_addr(REG_JUMP_LIMIT), 32'd0);
    write_reg(reg_addr(REG_TAU), 32'd0);
    write_reg(reg_addr(REG_PERIOD), 32'd0);
    // upper bits beyond the gain field must be dropped, unmapped writes ignored
    write_reg(reg_addr(REG_GAIN), 32'hFFFF_FFFF);
    write_reg(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    check_registers();
    send_pair(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, '0);
    send_pair(16'h8000, 16'h7FFF, 1'b1, 1'b1, '0);
    drain();
  endtask

  function automatic logic [31:0] pick_span(input logic [31:0] top, input logic [31:0] usual);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return top;
      default: return $urandom_range(0, usual);
    endcase
  endfunction

  function automatic logic [15:0] jitter(input logic [15:0] base, input int amp);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * amp)) - amp;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // Each phase picks a register set and a pressure/temperature operating point near the
  // origin, so most pairs land in range and exercise the filter rather than saturating.
  task automatic test_random_flight();
    logic [15:0] base_p;
    logic [15:0] base_t;
    logic        newer;
    longint      origin;
    int          amp;
    sample_t     s;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      sender_idle_en = (ph != 1);
      stall_en       = (ph != 1);
      newer  = 1'($urandom_range(0, 1));
      base_p = 16'($urandom);
      base_t = 16'($urandom);
      case ($urandom_range(0, 2))
        0:       amp = 2;
        1:       amp = 300;
        default: amp = 65535;
      endcase
      origin = longint'(base_p) + temp_term(newer, base_t)
               + longint'($urandom_range(0, 100)) - 64'sd50;
      if ($urandom_range(0, 7) == 0) begin
        origin = $urandom_range(0, 1) ? longint'(ORIGIN_MAX) : 64'sd0;
      end
      if (origin < 0) origin = 0;
      if (origin > longint'(ORIGIN_MAX)) origin = longint'(ORIGIN_MAX);
      write_reg(reg_addr(REG_SENSOR_TYPE), 32'(newer));
      write_reg(reg_addr(REG_ORIGIN), 32'(origin));
      write_reg(reg_addr(REG_GAIN), pick_span(32'h000F_FFFF, 32'd65535));
      write_reg(reg_addr(REG_JUMP_LIMIT), pick_span(32'h7FFF_FFFF, 32'h0100_0000));
      write_reg(reg_addr(REG_TAU), pick_span(32'h0000_FFFF, 32'd2048));
      write_reg(reg_addr(REG_PERIOD), pick_span(32'h0000_FFFF, 32'd8192));
      check_registers();

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        s.read_ok = ($urandom_range(0, 99) >= 8);
        if ($urandom_range(0, 99) < 5) begin
          s.raw_reading = 16'($urandom);
        end else begin
          s.raw_reading = jitter(want_pressure ? base_p : base_t, amp);
        end
        if ($urandom_range(0, 99) < 70) begin
          s.accel_valid = 1'b1;
          s.near_level  = 1'b1;
        end else begin
          s.accel_valid = 1'($urandom_range(0, 1));
          s.near_level  = 1'($urandom_range(0, 1));
        end
        s.in_flight         = 1'($urandom_range(0, 1));
        s.fallback_altitude = $urandom;
        send_sample(s);
      end
      drain();
    end
  endtask

  // in-flight read failures and forced jumps both raise the failure counter
  task automatic test_failure_counting();
    write_reg(reg_addr(REG_JUMP_LIMIT), 32'd0);
    write_reg(reg_addr(REG_GAIN), 32'h000F_FFFF);
    for (int k = 0; k < 8; k++) begin
      send_sample(make_sample(16'($urandom), 1'b0, 1'b1, 1'b1, 1'b1, $urandom));
      send_pair(16'($urandom), 16'($urandom), 1'b1, 1'b1, $urandom);
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    n_errors         = 0;
    n_samples        = 0;
    n_updates        = 0;
    n_failed_reads   = 0;
    n_jumps          = 0;
    n_fallback_loads = 0;
    sender_idle_en   = 1'b1;
    stall_en         = 1'b1;
    reset_model();
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample_beat  <= '0;
    result_stall <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_register_reset();
    test_pair_sequencing();
    test_read_failures();
    test_config_extremes();
    test_random_flight();
    test_failure_counting();

    $display("Sent %0d readings: %0d altitude updates, %0d failed reads, %0d jumps,",
             n_samples, n_updates, n_failed_reads, n_jumps);
    $display("  %0d fallback loads across register extremes and random phases; %0d mismatches",
             n_fallback_loads, n_errors);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
